/* rtl/base64_stream_decoder_unit_macros.svh */
// Assertion macros used by the base64 stream decoder checker.
`ifndef BASE64_STREAM_DECODER_UNIT_MACROS_SVH
`define BASE64_STREAM_DECODER_UNIT_MACROS_SVH

// Property checked on every clock edge while reset is released.
`define B64D_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define B64D_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/b64d_pkg.sv */
// Shared types, constants and the character decode function of the base64 decoder.
`timescale 1ns / 1ps

package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    // Output tuser bit positions
    localparam int TUSER_BYTE_VALID = 0;
    localparam int TUSER_TEXT_END   = 1;

    // One decoded job: all results caused by one input transaction
    typedef struct packed {
        logic [23:0] bytes;     // first result in the high byte
        logic [1:0]  n_res;     // 1 to 3 results
        logic        valid;     // 0 only for an empty end marker
        logic        text_end;  // last result closes the text
    } t_job;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet    s;
        logic [7:0] d;
        s.ok  = 1'b1;
        d     = 8'h00;
        case (c) inside
            [8'h41:8'h5A]: d = c - 8'h41;
            [8'h61:8'h7A]: d = c - 8'h47;
            [8'h30:8'h39]: d = c + 8'h04;
            CHAR_PLUS:     d = 8'd62;
            CHAR_SLASH:    d = 8'd63;
            default:       s.ok = 1'b0;
        endcase
        s.val = d[5:0];
        return s;
    endfunction

endpackage

/* rtl/b64d_front.sv */
// Front end: accepts characters, tracks the open group and builds result jobs.
`timescale 1ns / 1ps

module b64d_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_char,
    input  logic               i_present,
    input  logic               i_end,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output b64d_pkg::t_job     o_job
);

    logic [17:0]       r_acc, n_acc;
    logic [1:0]        r_gc, n_gc;
    logic              r_stop, n_stop;
    logic [1:0]        w_nres;
    logic              w_accept;
    b64d_pkg::t_sextet w_sx;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;
    assign w_sx     = b64d_pkg::sextet_of(i_char);

    always_comb begin
        n_acc          = r_acc;
        n_gc           = r_gc;
        n_stop         = r_stop;
        w_nres         = 2'd0;
        o_job.bytes    = 24'h000000;
        o_job.valid    = 1'b1;
        o_job.text_end = 1'b0;

        if (i_present && !r_stop) begin
            if (!w_sx.ok) begin
                n_stop = 1'b1;
            end else if (r_gc == 2'd3) begin
                o_job.bytes = {r_acc, w_sx.val};
                w_nres      = 2'd3;
                n_acc       = 18'h00000;
                n_gc        = 2'd0;
            end else begin
                n_acc = {r_acc[11:0], w_sx.val};
                n_gc  = r_gc + 2'd1;
            end
        end

        if (i_end) begin
            // flush a partial group, then return to the start state
            case (n_gc)
                2'd2: begin
                    o_job.bytes[23:16] = n_acc[11:4];
                    w_nres             = 2'd1;
                end
                2'd3: begin
                    o_job.bytes[23:8] = {n_acc[17:10], n_acc[9:2]};
                    w_nres            = 2'd2;
                end
                default: ;
            endcase
            if (w_nres == 2'd0) begin
                w_nres      = 2'd1;
                o_job.valid = 1'b0;
            end
            o_job.text_end = 1'b1;
            n_acc          = 18'h00000;
            n_gc           = 2'd0;
            n_stop         = 1'b0;
        end
        o_job.n_res = w_nres;
    end

    assign o_push = w_accept && (w_nres != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= 18'h00000;
            r_gc   <= 2'd0;
            r_stop <= 1'b0;
        end else if (w_accept) begin
            r_acc  <= n_acc;
            r_gc   <= n_gc;
            r_stop <= n_stop;
        end
    end

endmodule

/* rtl/b64d_queue.sv */
// Job queue between the front end and the byte emitter.
`timescale 1ns / 1ps

module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output b64d_pkg::t_job o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64d_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* rtl/b64d_back.sv */
// Back end: walks the head job one byte per cycle into the output register, while the output is not stalled.
`timescale 1ns / 1ps

module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  b64d_pkg::t_job i_q_head,
    output logic           o_pop,
    input  logic           i_tready,
    output logic           o_tvalid,
    output logic [7:0]     o_tdata,
    output logic [1:0]     o_tuser,
    output logic           o_tlast
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_data;
    logic [1:0] r_user;
    logic       r_last;
    logic       w_load;
    logic       w_emit;
    logic       w_last;
    logic [7:0] w_byte;

    assign w_load = !r_valid || i_tready;
    assign w_emit = w_load && i_q_valid;
    assign w_last = (r_idx == (i_q_head.n_res - 2'd1));
    assign o_pop  = w_emit && w_last;

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_q_head.bytes[23:16];
            2'd1:    w_byte = i_q_head.bytes[15:8];
            default: w_byte = i_q_head.bytes[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    // Payload needs no reset; it is qualified by r_valid
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_data                             <= w_byte;
            r_user[b64d_pkg::TUSER_BYTE_VALID] <= i_q_head.valid;
            r_user[b64d_pkg::TUSER_TEXT_END]   <= w_last && i_q_head.text_end;
            r_last                             <= w_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;
    assign o_tlast  = r_last;

endmodule

/* rtl/base64_stream_decoder_unit.sv */
// Top level of the streaming base64 decoder.
//
// Slave channel: one character per transaction. tdata carries the raw
// character, tuser[0] says a character is present, tlast marks the end of text.
// Master channel: one decoded byte per transaction. tuser[0] is byte valid,
// tuser[1] marks the last byte of the text, tlast the last result of one input.
// Every fourth character of a group gives three bytes; at end of text a partial
// group of i characters gives i-1 bytes, or a single empty result if none.
// The first non-base64 character stops decoding until the end of text.
// A transaction's first result passes the job queue, then the output register.
// Throughput: one character per cycle at the input while the queue is not full,
// one byte per cycle at the output while tready is high; the output rate sets the
// limit, and a job queue of Q_DEPTH entries absorbs the three-byte bursts.
// When the receiver stalls, the output register holds and the queue fills;
// tready drops only once the queue is full.
// Reset (synchronous, active low) empties the queue and output register and
// returns the decoder to the start of a text.
`timescale 1ns / 1ps

module base64_stream_decoder_unit #(
    parameter int Q_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_code
    input  logic [0:0] i_s_axis_tuser,   // [0] char_present
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] data_byte
    output logic [1:0] o_m_axis_tuser,   // [0] byte_valid, [1] text_end
    output logic       o_m_axis_tlast
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_q_valid;
    b64d_pkg::t_job w_job;
    b64d_pkg::t_job w_head;

    b64d_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_char    (i_s_axis_tdata),
        .i_present (i_s_axis_tuser[0]),
        .i_end     (i_s_axis_tlast),
        .i_q_full  (w_full),
        .o_ready   (o_s_axis_tready),
        .o_push    (w_push),
        .o_job     (w_job)
    );

    b64d_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    b64d_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_head  (w_head),
        .o_pop     (w_pop),
        .i_tready  (i_m_axis_tready),
        .o_tvalid  (o_m_axis_tvalid),
        .o_tdata   (o_m_axis_tdata),
        .o_tuser   (o_m_axis_tuser),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule

/* rtl/b64d_checker.sv */
// Port-level checker for the base64 decoder, bound to the top level.
`timescale 1ns / 1ps
`include "base64_stream_decoder_unit_macros.svh"

module b64d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // stalled transaction holds
    `B64D_ASSERT_RUN(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "output changed while stalled")

    // an empty result only closes a text
    `B64D_ASSERT_RUN(a_empty_is_end, o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tlast && o_m_axis_tuser[1], "empty result not at end of text")

    // end of text always ends the run of its input
    `B64D_ASSERT_RUN(a_end_is_last, o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tlast, "text end without run end")

    // reset drops the output
    `B64D_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_m_axis_tvalid, "output valid after reset")

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

/* tb/tb_top.sv */
// Self-checking testbench for the streaming base64 decoder unit.
`timescale 1ns / 1ps

// One character transaction offered to the decoder
typedef struct {
    logic [7:0] code;
    logic       present;
    logic       eot;
} char_item_t;

// One decoded byte transaction as it leaves the decoder
typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       text_end;
} out_byte_t;

// 6-bit value of a base64 character, -1 for anything else
function automatic int sextet_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 26;
    if (c >= "0" && c <= "9") return c - "0" + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
endfunction

function automatic logic [7:0] b64_char(int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return "+";
    return "/";
endfunction

function automatic char_item_t chr(logic [7:0] c, logic present, logic eot);
    char_item_t it;
    it.code    = c;
    it.present = present;
    it.eot     = eot;
    return it;
endfunction

class decoded_byte_board;
    bit [17:0]  acc;
    bit [1:0]   fill;
    bit         halted;
    out_byte_t  pending_bytes[$];
    int         errors;

    function void take_char(logic [7:0] code, logic present, logic eot);
        out_byte_t burst[$];
        int        v;
        bit [23:0] word;
        if (present && !halted) begin
            v = sextet_value(code);
            if (v < 0) begin
                halted = 1'b1;
            end else if (fill == 2'd3) begin
                word = {acc, v[5:0]};
                burst.push_back('{word[23:16], 1'b1, 1'b0, 1'b0});
                burst.push_back('{word[15:8], 1'b1, 1'b0, 1'b0});
                burst.push_back('{word[7:0], 1'b1, 1'b0, 1'b0});
                acc  = '0;
                fill = '0;
            end else begin
                acc  = {acc[11:0], v[5:0]};
                fill = fill + 2'd1;
            end
        end
        if (eot) begin
            // flush the partial group: i characters give i-1 bytes
            if (fill == 2'd2) begin
                burst.push_back('{acc[11:4], 1'b1, 1'b0, 1'b0});
            end else if (fill == 2'd3) begin
                burst.push_back('{acc[17:10], 1'b1, 1'b0, 1'b0});
                burst.push_back('{acc[9:2], 1'b1, 1'b0, 1'b0});
            end
            if (burst.size() == 0) burst.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
            burst[burst.size()-1].text_end = 1'b1;
            acc    = '0;
            fill   = '0;
            halted = 1'b0;
        end
        if (burst.size() > 0) begin
            burst[burst.size()-1].run_last = 1'b1;
            foreach (burst[i]) pending_bytes.push_back(burst[i]);
        end
    endfunction

    function void match_byte(out_byte_t got);
        out_byte_t exp;
        if (pending_bytes.size() == 0) begin
            $error("unexpected output transaction: data_byte %0h", got.data);
            errors++;
            return;
        end
        exp = pending_bytes.pop_front();
        if (got.data !== exp.data) begin
            $error("data_byte: expected %0h, got %0h", exp.data, got.data);
            errors++;
        end
        if (got.valid !== exp.valid) begin
            $error("byte_valid: expected %0b, got %0b", exp.valid, got.valid);
            errors++;
        end
        if (got.run_last !== exp.run_last) begin
            $error("run_last: expected %0b, got %0b", exp.run_last, got.run_last);
            errors++;
        end
        if (got.text_end !== exp.text_end) begin
            $error("text_end: expected %0b, got %0b", exp.text_end, got.text_end);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int RANDOM_CHARS = 220;
    localparam int CALM_AFTER   = 190;
    localparam int LONG_HOLD    = 64;
    localparam int STALL_LIMIT  = 1000;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_valid  = 1'b0;
    logic [7:0] s_data   = 8'h00;
    logic [0:0] s_user   = 1'b0;
    logic       s_last   = 1'b0;
    logic       m_tready = 1'b0;

    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;   // [7:0] data_byte
    logic [1:0] o_m_axis_tuser;   // [0] byte_valid, [1] text_end
    logic       o_m_axis_tlast;

    decoded_byte_board board = new;

    bit hold_req;
    bit calm;
    int chars_fed;
    int stall_cycles;

    base64_stream_decoder_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),     // [7:0] char_code
        .i_s_axis_tuser  (s_user),     // [0] char_present
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 clk = ~clk;

    // Note accepted characters first, then check decoded bytes
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                board.take_char(s_data, s_user[0], s_last);
            end
            if (o_m_axis_tvalid && m_tready) begin
                board.match_byte('{o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tlast,
                                   o_m_axis_tuser[1]});
            end
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
        end
    end

    initial begin
        wait (rst_n);
        while (stall_cycles < STALL_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random back-pressure bursts, one long hold on request
    initial begin
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(char_item_t it);
        @(negedge clk);
        s_valid <= 1'b1;
        s_data  <= it.code;
        s_user  <= it.present;
        s_last  <= it.eot;
        do @(posedge clk); while (!o_s_axis_tready);
        chars_fed++;
    endtask

    task automatic pause_sender(int n);
        @(negedge clk);
        s_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (board.pending_bytes.size() != 0) @(posedge clk);
    endtask

    // Build one text, mostly well-formed with random content, then feed it
    task automatic play_text();
        char_item_t items[$];
        int         n;
        n = 0;
        if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(0, 13);
            repeat (n) items.push_back(chr(b64_char($urandom_range(0, 63)), 1'b1, 1'b0));
            if (n % 4 == 2 && $urandom_range(0, 1)) begin
                items.push_back(chr("=", 1'b1, 1'b0));
                items.push_back(chr("=", 1'b1, 1'b0));
            end else if (n % 4 == 3 && $urandom_range(0, 1)) begin
                items.push_back(chr("=", 1'b1, 1'b0));
            end
            // trailing junk after a stop must be ignored
            if ($urandom_range(0, 5) == 0)
                items.push_back(chr(8'($urandom_range(0, 255)), 1'b1, 1'b0));
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                items.push_back(chr($urandom_range(0, 1) ? b64_char($urandom_range(0, 63))
                                                         : 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 5) != 0), 1'b0));
            end
        end
        if (items.size() > 0 && $urandom_range(0, 1))
            items[items.size()-1].eot = 1'b1;
        else
            items.push_back(chr(8'($urandom_range(0, 255)), 1'b0, 1'b1));

        foreach (items[i]) begin
            if (!calm && !hold_req && $urandom_range(0, 6) == 0)
                pause_sender($urandom_range(1, 18));
            if ($urandom_range(0, 14) == 0)
                send_item(chr(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            send_item(items[i]);
        end
    endtask

    initial begin
        char_item_t directed[$];
        bit         paused_once;
        paused_once = 1'b0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // full groups over the alphabet edges
        directed.push_back(chr("A", 1'b1, 1'b0));
        directed.push_back(chr("Z", 1'b1, 1'b0));
        directed.push_back(chr("a", 1'b1, 1'b0));
        directed.push_back(chr("z", 1'b1, 1'b0));
        directed.push_back(chr("0", 1'b1, 1'b0));
        directed.push_back(chr("9", 1'b1, 1'b0));
        directed.push_back(chr("+", 1'b1, 1'b0));
        directed.push_back(chr("/", 1'b1, 1'b0));
        // no character and no end: nothing happens
        directed.push_back(chr(8'hFF, 1'b0, 1'b0));
        // padding stops decoding, later characters ignored, lone char gives empty end
        directed.push_back(chr("Q", 1'b1, 1'b0));
        directed.push_back(chr("=", 1'b1, 1'b0));
        directed.push_back(chr("x", 1'b1, 1'b0));
        directed.push_back(chr("y", 1'b1, 1'b1));
        // two leftovers closed by a bare end marker
        directed.push_back(chr("T", 1'b1, 1'b0));
        directed.push_back(chr("W", 1'b1, 1'b0));
        directed.push_back(chr(8'h00, 1'b0, 1'b1));
        // three leftovers, end on the last character
        directed.push_back(chr("T", 1'b1, 1'b0));
        directed.push_back(chr("W", 1'b1, 1'b0));
        directed.push_back(chr("F", 1'b1, 1'b1));
        // top bit set stops decoding, then empty end
        directed.push_back(chr(8'h80, 1'b1, 1'b1));
        directed.push_back(chr(8'h00, 1'b0, 1'b1));
        // group completed by the end character itself
        directed.push_back(chr("A", 1'b1, 1'b0));
        directed.push_back(chr("B", 1'b1, 1'b0));
        directed.push_back(chr("C", 1'b1, 1'b0));
        directed.push_back(chr("D", 1'b1, 1'b1));
        foreach (directed[i]) send_item(directed[i]);

        // receiver stalls long while characters keep coming
        hold_req = 1'b1;
        while (chars_fed < RANDOM_CHARS) begin
            play_text();
            if (!paused_once && chars_fed >= RANDOM_CHARS / 2) begin
                // drain completely before resuming
                pause_sender(1);
                wait_drained();
                paused_once = 1'b1;
            end
            calm = (chars_fed >= CALM_AFTER);
        end
        @(negedge clk);
        s_valid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
